FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; included by bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: src/fbt_pkg.sv
// Package for the firmware block tracker: sizes, codes and state types.
// Depends on nothing.
package fbt_pkg;
  localparam int MaxBlocks  = 1024;
  localparam int BlockBytes = 64;
  localparam int ReqMax     = 16;
  localparam int ReqLim     = (ReqMax < 16) ? ReqMax : 16;
  localparam int IdxW       = $clog2(MaxBlocks);
  localparam int CntW       = IdxW + 1;
  localparam int ShW        = $clog2(BlockBytes);
  localparam int ReqW       = $clog2(ReqLim + 1);
  localparam logic [20:0] MaxLen = 21'(MaxBlocks * BlockBytes);

  typedef enum logic [1:0] {
    PH_INVALID = 2'd0, PH_INIT = 2'd1, PH_RECEIVING = 2'd2, PH_READY = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    OP_START = 2'd0, OP_DATA = 2'd1, OP_CHECK = 2'd2, OP_UPDATE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_REJECT = 3'd0, K_ACCEPT = 3'd1, K_MISSING = 3'd2, K_READY = 3'd3,
    K_COPY = 3'd4, K_PROGRESS = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DIV, S_SCAN, S_EMIT, S_OUT
  } state_t;

  localparam logic [1:0] CFG_RUNNING   = 2'd0;
  localparam logic [1:0] CFG_DOWNGRADE = 2'd1;
endpackage

FILE: src/firmware_block_tracker.sv
// Firmware image reception tracker, top level.
// Depends on fbt_pkg.
//
// Use: input items (operation and its fields) arrive on a valid/ready channel;
// result items leave on a second valid/ready channel, one transfer each, with
// last set on the final result caused by an input. Configuration registers are
// to be written through a plain write port only while the block is idle; the
// block itself does not enforce this. After reset the block sweeps all MaxBlocks
// (1024) entries of its received-block bitmap to zero, one entry a cycle,
// before in_ready first rises; a session start with no stored length or an
// invalid phase, and a data block that starts or changes an image, repeat that
// sweep before their result. A rejection, ready notice, copy or length verdict
// is loaded into the result register at dispatch. A data block without a sweep
// passes dispatch, bitmap read and update before its result is valid. A session
// start with a stored length runs a shift-subtract divider for the percentage:
// dispatch, then the quotient bits one at a time, then a step that loads the
// result. A length check reads and then tests each bitmap entry up to the block
// total; every missing id but the final one is held until the next missing
// entry is found, and that entry is read again after the transfer. The bitmap
// memory (one read and one write a cycle) and the one divider set the pace. One
// item is worked on at a time; in_ready stays low until the last result of the
// item has been transferred and rises the cycle after. When the receiver stalls,
// the result register simply holds and nothing is lost.
module firmware_block_tracker import fbt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [15:0] offered_version,
  input  logic [15:0] block_index,
  input  logic [19:0] image_length,
  input  logic        crc_match,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic        erase_flash,
  output logic        write_block,
  output logic [19:0] write_address,
  output logic [9:0]  missing_id,
  output logic [6:0]  progress_percent,
  output logic [15:0] notice_version,
  output logic        last
);
  logic [15:0] running_version;
  logic        allow_downgrade;
  phase_t      phase;
  logic [15:0] image_version;
  logic [19:0] stored_length;
  logic [CntW-1:0] received_count;
  logic        received_map [MaxBlocks];
  state_t      state, state_next;

  // Latched input item.
  logic [1:0]  op;
  logic [15:0] ver;
  logic [15:0] idx;
  logic [19:0] len;
  logic        crc;

  // Bitmap sweep / scan counter, total blocks, and result count.
  logic [CntW-1:0] ptr;
  logic [CntW-1:0] total;
  logic [ReqW-1:0] sent;
  logic            map_rd;
  logic            scan_pend;
  logic            after_clear;
  // A missing id is loaded in the result register but not yet offered.
  logic            held;

  // Divider: quotient of count*100 by total, restoring, one bit a cycle.
  logic [CntW+6:0] dividend;
  logic [CntW+6:0] rem;
  logic [4:0]      dstep;
  logic [CntW+7:0] div_trial;
  assign div_trial = {rem, dividend[CntW+6]} - {8'd0, total};

  logic [CntW-1:0] len_total;
  assign len_total = CntW'((len + 20'(BlockBytes - 1)) >> ShW);
  logic [CntW-1:0] st_total;
  assign st_total = CntW'((stored_length + 20'(BlockBytes - 1)) >> ShW);

  logic gate_fail;
  assign gate_fail = !allow_downgrade && (ver <= running_version);

  logic idx_bad, len_bad, start_clear, data_restart, ptr_end, req_full;
  assign idx_bad      = (idx >= 16'(MaxBlocks));
  assign len_bad      = (len == '0) || ({1'b0, len} > MaxLen);
  assign start_clear  = (stored_length == '0) || (phase == PH_INVALID);
  assign data_restart = (phase == PH_INVALID) || (phase == PH_INIT) || (ver != image_version);
  assign ptr_end      = (ptr + 1'b1 >= total);
  assign req_full     = (sent + 1'b1 == ReqW'(ReqLim));

  always_ff @(posedge clk) begin
    if (rst) begin
      running_version <= '0;
      allow_downgrade <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_RUNNING) running_version <= cfg_data;
      else if (cfg_index == CFG_DOWNGRADE) allow_downgrade <= cfg_data[0];
    end
  end

  // Bitmap memory: one write and one read per cycle.
  logic            map_we, map_wd;
  logic [IdxW-1:0] map_wa, map_ra;
  always_ff @(posedge clk) begin
    if (map_we) received_map[map_wa] <= map_wd;
    map_rd <= received_map[map_ra];
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (ptr == CntW'(MaxBlocks - 1)) begin
          if (scan_pend) state_next = S_DIV;
          else if (after_clear) state_next = S_OUT;
          else state_next = S_IDLE;
        end
      end
      S_IDLE:  if (in_valid) state_next = S_DIV;
      S_DIV: begin
        if (dstep == 5'd0) begin
          unique case (op_t'(op))
            OP_START: if (start_clear) state_next = S_CLEAR;
            OP_DATA: begin
              if (gate_fail || idx_bad) state_next = S_OUT;
              else if (data_restart) state_next = S_CLEAR;
            end
            OP_CHECK: begin
              if (!gate_fail && phase != PH_READY && !len_bad
                  && received_count < len_total) state_next = S_SCAN;
              else state_next = S_OUT;
            end
            default: state_next = S_OUT;
          endcase
        end else if (op == OP_DATA) begin
          state_next = S_EMIT;
        end else if (dstep == 5'(CntW + 8)) begin
          state_next = S_OUT;
        end
      end
      S_SCAN:  state_next = S_EMIT;
      S_EMIT: begin
        if (op == OP_DATA) state_next = S_OUT;
        else if (!map_rd) state_next = (held || ptr_end || req_full) ? S_OUT : S_SCAN;
        else state_next = ptr_end ? S_OUT : S_SCAN;
      end
      S_OUT:   if (out_ready) state_next = (!last) ? S_SCAN : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory addressing; S_DIV is the dispatch/divide state, S_SCAN reads, S_EMIT checks.
  always_comb begin
    map_we = 1'b0;
    map_wd = 1'b0;
    map_wa = ptr[IdxW-1:0];
    map_ra = ptr[IdxW-1:0];
    if (state == S_CLEAR) map_we = 1'b1;
    else if (state == S_DIV && op == OP_DATA && dstep == 5'd1) map_ra = idx[IdxW-1:0];
    else if (state == S_EMIT && op == OP_DATA) begin
      map_wa = idx[IdxW-1:0];
      map_we = (phase != PH_READY) && !map_rd;
      map_wd = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ptr <= '0;
      after_clear <= 1'b0;
      phase <= PH_INVALID;
      image_version <= '0;
      stored_length <= '0;
      received_count <= '0;
      out_valid <= 1'b0;
      dstep <= '0;
      sent <= '0;
      scan_pend <= 1'b0;
      held <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR: begin
          if (ptr == CntW'(MaxBlocks - 1)) begin
            ptr <= '0;
            after_clear <= 1'b0;
            scan_pend <= 1'b0;
            // After a clear for a data block, continue into the bitmap read.
            if (scan_pend) dstep <= 5'd1;
            else if (after_clear) out_valid <= 1'b1;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op <= operation; ver <= offered_version; idx <= block_index;
            len <= image_length; crc <= crc_match;
            dstep <= '0;
          end
        end
        S_DIV: begin
          // Dispatch on the first cycle (dstep 0); later cycles read the bitmap
          // for a data block or run the divider.
          dstep <= dstep + 1'b1;
          if (dstep == 5'd0) begin
            kind <= K_REJECT; erase_flash <= 1'b0; write_block <= 1'b0;
            write_address <= '0; missing_id <= '0; progress_percent <= '0;
            notice_version <= '0; last <= 1'b1;
            unique case (op_t'(op))
              OP_START: begin
                kind <= K_PROGRESS;
                if (start_clear) begin
                  erase_flash <= 1'b1;
                  phase <= PH_INIT; image_version <= '0; stored_length <= '0;
                  received_count <= '0; ptr <= '0; after_clear <= 1'b1;
                end else begin
                  dividend <= (CntW+7)'(received_count) * (CntW+7)'(100);
                  rem <= '0;
                  total <= st_total;
                end
              end
              OP_DATA: begin
                if (gate_fail || idx_bad) begin
                  out_valid <= 1'b1;
                end else begin
                  kind <= K_ACCEPT;
                  if (data_restart) begin
                    erase_flash <= (phase == PH_INVALID) || (ver != image_version);
                    phase <= PH_RECEIVING; image_version <= ver; stored_length <= '0;
                    received_count <= '0; ptr <= '0;
                    scan_pend <= 1'b1;
                  end
                end
              end
              OP_CHECK: begin
                if (gate_fail) begin
                  out_valid <= 1'b1;
                end else if (phase == PH_READY) begin
                  kind <= K_READY; notice_version <= image_version;
                  out_valid <= 1'b1;
                end else if (len_bad) begin
                  out_valid <= 1'b1;
                end else begin
                  stored_length <= len;
                  total <= len_total;
                  if (received_count < len_total) begin
                    ptr <= '0; sent <= '0; held <= 1'b0;
                  end else if (!crc) begin
                    phase <= PH_INVALID; out_valid <= 1'b1;
                  end else begin
                    phase <= PH_READY; kind <= K_READY;
                    notice_version <= image_version;
                    out_valid <= 1'b1;
                  end
                end
              end
              default: begin
                if (gate_fail || phase != PH_READY) begin
                  out_valid <= 1'b1;
                end else if (!crc) begin
                  phase <= PH_INVALID; out_valid <= 1'b1;
                end else begin
                  kind <= K_COPY; out_valid <= 1'b1;
                end
              end
            endcase
          end else if (op != OP_DATA) begin
            // Progress division: one quotient bit per cycle, then load the result.
            if (dstep == 5'(CntW + 8)) begin
              progress_percent <= (dividend > (CntW+7)'(100)) ? 7'd100 : 7'(dividend);
              out_valid <= 1'b1;
            end else if (!div_trial[CntW+7]) begin
              rem <= div_trial[CntW+6:0];
              dividend <= {dividend[CntW+5:0], 1'b1};
            end else begin
              rem <= {rem[CntW+5:0], dividend[CntW+6]};
              dividend <= {dividend[CntW+5:0], 1'b0};
            end
          end
        end
        S_SCAN: ; // Read of ptr issued; the bit is tested next cycle.
        S_EMIT: begin
          if (op == OP_DATA) begin
            if (phase != PH_READY && !map_rd) begin
              received_count <= received_count + 1'b1;
              write_block <= 1'b1;
              write_address <= 20'(idx[IdxW-1:0]) << ShW;
            end
            out_valid <= 1'b1;
          end else if (!map_rd) begin
            if (held) begin
              // Another id follows, so the held one goes out with last clear;
              // this entry is read again after the transfer.
              out_valid <= 1'b1;
              held <= 1'b0;
            end else begin
              kind <= K_MISSING; missing_id <= 10'(ptr); notice_version <= image_version;
              sent <= sent + 1'b1;
              if (ptr_end || req_full) begin
                last <= 1'b1;
                out_valid <= 1'b1;
              end else begin
                last <= 1'b0;
                held <= 1'b1;
                ptr <= ptr + 1'b1;
              end
            end
          end else if (ptr_end) begin
            // End of the scan: a held id is the final one; with none held the
            // count was short but nothing is missing, and the result is a rejection.
            last <= 1'b1;
            out_valid <= 1'b1;
            held <= 1'b0;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_OUT: begin
          if (out_ready) out_valid <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: src/fbt_checker.sv
// Port-level checker for the firmware block tracker, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module fbt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  kind,
  input logic        last
);
  `CHK_IMPL(a_no_overlap, clk, rst, out_valid, !in_ready, "input taken while result pending")
  `CHK_IMPL(a_kind_range, clk, rst, out_valid, kind <= 3'd5, "result kind out of range")
  `CHK_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped under stall")
  `CHK_NEXT(a_busy, clk, rst, in_valid && in_ready, !in_ready, "ready stayed high after transfer")
endmodule

bind firmware_block_tracker fbt_checker u_fbt_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .last(last)
);
